// ===== hw/rtl/lru_k_frame_replacer_defines.svh =====
// Assertion macros shared by the LRU-K replacer RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef LRU_K_FRAME_REPLACER_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LKR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkr_pkg.sv =====
// Package for the LRU-K frame replacer: payload structs, op codes,
// configuration indexes and default sizes. No dependencies.
`default_nettype none
package lkr_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int MAX_K_DEF      = 8;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [1:0] OP_ACCESS    = 2'd0;
  localparam logic [1:0] OP_SET_EVICT = 2'd1;
  localparam logic [1:0] OP_REMOVE    = 2'd2;
  localparam logic [1:0] OP_EVICT     = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_DEPTH = 1'd1;

  localparam logic [6:0] FRAME_LIMIT_RST   = 7'd64;
  localparam logic [3:0] HISTORY_DEPTH_RST = 4'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] frame;
    logic       evictable_flag;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] victim;
    logic [6:0] evictable_count;
  } out_item_t;

  // Control from the scan pipeline to the victim selector
  typedef struct packed {
    logic start;
    logic cand_valid;
    logic cand_inf;
  } sel_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lkr_sync_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port,
// read data registered. No dependencies.
`default_nettype none
module lkr_sync_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lkr_victim_sel.sv =====
// Running best-candidate tracker for the evict scan.
// Depends on lkr_pkg for the control struct.
`default_nettype none
module lkr_victim_sel #(
  parameter int FW = 6,
  parameter int SB = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lkr_pkg::sel_ctrl_t ctrl,
  input  wire logic [SB-1:0]     cand_key,
  input  wire logic [FW-1:0]     cand_frame,
  output logic                   have,
  output logic [FW-1:0]          best_frame
);
  import lkr_pkg::*;

  logic          have_r;
  logic          inf_r;
  logic [SB-1:0] key_r;
  logic [FW-1:0] frame_r;
  logic          take;

  // Infinite distance beats finite; then oldest key; ties keep the lower frame
  assign take = ctrl.cand_valid &&
                (!have_r || (ctrl.cand_inf && !inf_r) ||
                 ((ctrl.cand_inf == inf_r) && (cand_key < key_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctrl.start) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  // Hold best key and frame
  always_ff @(posedge clk) begin
    if (!ctrl.start && take) begin
      inf_r   <= ctrl.cand_inf;
      key_r   <= cand_key;
      frame_r <= cand_frame;
    end
  end

  assign have       = have_r;
  assign best_frame = frame_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lru_k_frame_replacer.sv =====
// LRU-K frame replacer: takes one operation per transfer (access, set evictable,
// remove, evict) and returns one result each. Per-frame metadata (evictable flag,
// access count, ring head) sits in one RAM and the access stamp rings in a second
// RAM; every op is a read-modify-write of these. After reset a clearing pass over
// every frame zeroes the metadata RAM, during which no item is accepted. Access,
// set-evictable and remove go through the metadata write-back state, then the
// output state; evict scans every frame through a two-stage read pipeline
// (metadata, then stamp), one frame per cycle. One item is in work at a
// time; a new item is taken once the previous result sits in the output register.
// Depends on lkr_pkg, lkr_sync_ram, lkr_victim_sel and the assertion macro header.
`default_nettype none
`include "lru_k_frame_replacer_defines.svh"
module lru_k_frame_replacer #(
  parameter int MAX_FRAMES = lkr_pkg::MAX_FRAMES_DEF,
  parameter int MAX_K      = lkr_pkg::MAX_K_DEF,
  parameter int STAMP_BITS = lkr_pkg::STAMP_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire lkr_pkg::in_item_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output lkr_pkg::out_item_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [lkr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lkr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import lkr_pkg::*;

  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int IW  = FW + 1;
  localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int SW  = KW + 1;
  localparam int CW  = $clog2(MAX_K + 1);
  localparam int MW  = 1 + CW + KW;
  localparam int ETW = $clog2(MAX_FRAMES + 1);
  localparam int SD  = MAX_FRAMES * MAX_K;
  localparam int AW  = (SD > 1) ? $clog2(SD) : 1;
  localparam logic [IW-1:0] FRAMES_END = IW'(MAX_FRAMES);
  localparam logic [IW-1:0] CLR_LAST   = IW'(MAX_FRAMES - 1);
  localparam logic [AW-1:0] K_AW       = AW'(MAX_K);
  localparam logic [SW-1:0] K_SW       = SW'(MAX_K);
  localparam logic [KW-1:0] HEAD_LAST  = KW'(MAX_K - 1);
  localparam logic [CW-1:0] K_CW       = CW'(MAX_K);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_META, ST_SCAN, ST_COMMIT, ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [5:0]            frame_r, frame_nxt;
  logic                  flag_r, flag_nxt;
  logic                  in_store_r, in_store_nxt;
  logic                  in_limit_r, in_limit_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [ETW-1:0]        etotal_r, etotal_nxt;
  logic [6:0]            flim_r;
  logic [3:0]            hdep_r;
  logic                  p1_act_r, p1_act_nxt;
  logic [FW-1:0]         p1_frame_r, p1_frame_nxt;
  logic                  p2_act_r, p2_act_nxt;
  logic                  p2_elig_r, p2_elig_nxt;
  logic                  p2_inf_r, p2_inf_nxt;
  logic [FW-1:0]         p2_frame_r, p2_frame_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [5:0]            res_victim_r, res_victim_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // Memory ports
  logic                  meta_we, meta_re;
  logic [FW-1:0]         meta_wa, meta_ra;
  logic [MW-1:0]         meta_wd, meta_q;
  logic                  st_we, st_re;
  logic [AW-1:0]         st_wa, st_ra;
  logic [STAMP_BITS-1:0] st_wd, st_q;

  // Selector
  sel_ctrl_t             sel_ctrl;
  logic                  sel_have;
  logic [FW-1:0]         sel_best;

  // Decoded metadata and scan math
  logic                  q_ev;
  logic [CW-1:0]         q_cnt;
  logic [KW-1:0]         q_head;
  logic [CW-1:0]         eff_k;
  logic                  q_inf;
  logic [CW-1:0]         q_dist;
  logic [SW-1:0]         slot_raw;
  logic [KW-1:0]         slot;
  logic [KW-1:0]         head_inc;
  logic [CW-1:0]         cnt_inc;
  logic [FW-1:0]         op_frame;

  lkr_sync_ram #(.DEPTH(MAX_FRAMES), .WIDTH(MW)) u_meta_ram (
    .clk(clk), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
    .rd_en(meta_re), .rd_addr(meta_ra), .rd_data(meta_q)
  );

  lkr_sync_ram #(.DEPTH(SD), .WIDTH(STAMP_BITS)) u_stamp_ram (
    .clk(clk), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
    .rd_en(st_re), .rd_addr(st_ra), .rd_data(st_q)
  );

  lkr_victim_sel #(.FW(FW), .SB(STAMP_BITS)) u_victim_sel (
    .clk(clk), .rst_n(rst_n), .ctrl(sel_ctrl), .cand_key(st_q),
    .cand_frame(p2_frame_r), .have(sel_have), .best_frame(sel_best)
  );

  // Unpack metadata word {evictable, count, head}
  assign q_ev   = meta_q[MW-1];
  assign q_cnt  = meta_q[KW +: CW];
  assign q_head = meta_q[KW-1:0];

  // Clamp K into 1..MAX_K
  always_comb begin
    if (hdep_r == 4'd0) begin
      eff_k = CW'(1);
    end else if (int'(hdep_r) > MAX_K) begin
      eff_k = K_CW;
    end else begin
      eff_k = CW'(hdep_r);
    end
  end

  // Ring slot of the d-th most recent access
  assign q_inf    = q_cnt < eff_k;
  assign q_dist   = q_inf ? q_cnt : eff_k;
  assign slot_raw = SW'(q_head) + K_SW - SW'(q_dist);
  assign slot     = (slot_raw >= K_SW) ? KW'(slot_raw - K_SW) : KW'(slot_raw);
  assign head_inc = (q_head == HEAD_LAST) ? '0 : q_head + KW'(1);
  assign cnt_inc  = (q_cnt == K_CW) ? q_cnt : q_cnt + CW'(1);
  assign op_frame = FW'(frame_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    frame_nxt      = frame_r;
    flag_nxt       = flag_r;
    in_store_nxt   = in_store_r;
    in_limit_nxt   = in_limit_r;
    stamp_nxt      = stamp_r;
    etotal_nxt     = etotal_r;
    p1_act_nxt     = 1'b0;
    p1_frame_nxt   = p1_frame_r;
    p2_act_nxt     = 1'b0;
    p2_elig_nxt    = 1'b0;
    p2_inf_nxt     = p2_inf_r;
    p2_frame_nxt   = p2_frame_r;
    res_found_nxt  = res_found_r;
    res_victim_nxt = res_victim_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    meta_we        = 1'b0;
    meta_wa        = op_frame;
    meta_wd        = '0;
    meta_re        = 1'b0;
    meta_ra        = FW'(in_data.frame);
    st_we          = 1'b0;
    st_wa          = AW'(op_frame) * K_AW + AW'(q_head);
    st_wd          = stamp_r;
    st_re          = 1'b0;
    st_ra          = AW'(p1_frame_r) * K_AW + AW'(slot);
    sel_ctrl       = '0;

    // Drop the output once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = idx_r[FW-1:0];
        if (idx_r == CLR_LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          frame_nxt      = in_data.frame;
          flag_nxt       = in_data.evictable_flag;
          in_store_nxt   = int'(in_data.frame) < MAX_FRAMES;
          in_limit_nxt   = {1'b0, in_data.frame} < flim_r;
          stamp_nxt      = (stamp_r == '1) ? stamp_r : stamp_r + STAMP_BITS'(1);
          res_found_nxt  = 1'b0;
          res_victim_nxt = '0;
          meta_re        = 1'b1;
          if (in_data.op == OP_EVICT) begin
            idx_nxt        = '0;
            sel_ctrl.start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_META;
          end
        end
      end

      ST_META: begin
        // Modify and write back the named frame
        unique case (op_r)
          OP_ACCESS: begin
            if (in_store_r && in_limit_r) begin
              st_we   = 1'b1;
              meta_we = 1'b1;
              meta_wd = {q_ev, cnt_inc, head_inc};
            end
          end
          OP_SET_EVICT: begin
            if (in_store_r) begin
              if (flag_r) begin
                if ((q_cnt != '0) && !q_ev) begin
                  meta_we    = 1'b1;
                  meta_wd    = {1'b1, q_cnt, q_head};
                  etotal_nxt = etotal_r + ETW'(1);
                end
              end else if (q_ev) begin
                meta_we    = 1'b1;
                meta_wd    = {1'b0, q_cnt, q_head};
                etotal_nxt = etotal_r - ETW'(1);
              end
            end
          end
          OP_REMOVE: begin
            if (in_store_r) begin
              meta_we = 1'b1;
              if (q_ev && (etotal_r != '0)) begin
                etotal_nxt = etotal_r - ETW'(1);
              end
            end
          end
          OP_EVICT: begin
          end
        endcase
        state_nxt = ST_OUT;
      end

      ST_SCAN: begin
        // Stage 0: issue metadata read
        if (idx_r != FRAMES_END) begin
          meta_re      = 1'b1;
          meta_ra      = idx_r[FW-1:0];
          p1_act_nxt   = 1'b1;
          p1_frame_nxt = idx_r[FW-1:0];
          idx_nxt      = idx_r + IW'(1);
        end
        // Stage 1: metadata back, issue stamp read
        if (p1_act_r) begin
          st_re        = 1'b1;
          p2_act_nxt   = 1'b1;
          p2_elig_nxt  = q_ev && (q_cnt != '0);
          p2_inf_nxt   = q_inf;
          p2_frame_nxt = p1_frame_r;
        end
        // Stage 2: stamp back, offer candidate
        sel_ctrl.cand_valid = p2_act_r && p2_elig_r;
        sel_ctrl.cand_inf   = p2_inf_r;
        if ((idx_r == FRAMES_END) && !p1_act_r && !p2_act_r) begin
          state_nxt = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        // Clear the victim's history
        if (sel_have) begin
          meta_we        = 1'b1;
          meta_wa        = sel_best;
          res_found_nxt  = 1'b1;
          res_victim_nxt = 6'(sel_best);
          if (etotal_r != '0) begin
            etotal_nxt = etotal_r - ETW'(1);
          end
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: res_found_r, victim: res_victim_r,
                            evictable_count: 7'(etotal_r)};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      stamp_r     <= '0;
      etotal_r    <= '0;
      p1_act_r    <= 1'b0;
      p2_act_r    <= 1'b0;
      p2_elig_r   <= 1'b0;
      out_valid_r <= 1'b0;
      res_found_r <= 1'b0;
      flim_r      <= FRAME_LIMIT_RST;
      hdep_r      <= HISTORY_DEPTH_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      stamp_r     <= stamp_nxt;
      etotal_r    <= etotal_nxt;
      p1_act_r    <= p1_act_nxt;
      p2_act_r    <= p2_act_nxt;
      p2_elig_r   <= p2_elig_nxt;
      out_valid_r <= out_valid_nxt;
      res_found_r <= res_found_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_LIMIT:   flim_r <= cfg_wdata[6:0];
          CFG_HISTORY_DEPTH: hdep_r <= cfg_wdata[3:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    frame_r      <= frame_nxt;
    flag_r       <= flag_nxt;
    in_store_r   <= in_store_nxt;
    in_limit_r   <= in_limit_nxt;
    p1_frame_r   <= p1_frame_nxt;
    p2_inf_r     <= p2_inf_nxt;
    p2_frame_r   <= p2_frame_nxt;
    res_victim_r <= res_victim_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LKR_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "item overlap")
  `LKR_ASSERT_IMPLIES(a_scan_bound, state_r == ST_SCAN, idx_r <= FRAMES_END, "scan overrun")
  `LKR_ASSERT_IMPLIES(a_meta_no_found, state_r == ST_META, !res_found_r, "found on non-evict")
  `LKR_ASSERT_IMPLIES(a_victim_counted, state_r == ST_COMMIT && sel_have, etotal_r != '0,
                      "victim without evictable count")

endmodule
`default_nettype wire

// ===== tb/tb_lru_k_frame_replacer.sv =====
// Self-checking testbench for lru_k_frame_replacer: a queue-fed driver, a monitor,
// and an LRU-K victim predictor. Depends on lkr_pkg and the replacer RTL.
`timescale 1ns / 1ps
module tb_lru_k_frame_replacer;
  import lkr_pkg::*;

  localparam int NFR        = 64;
  localparam int KMAX       = 8;
  localparam int SETTLE     = 100;
  localparam int CYCLE_CAP  = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lru_k_frame_replacer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow replacer state
  bit          fr_tracked [NFR];
  bit          fr_evict   [NFR];
  int unsigned fr_count   [NFR];
  int unsigned fr_head    [NFR];
  logic [31:0] fr_stamps  [NFR][KMAX];
  logic [31:0] stamp_now;
  int unsigned evict_total;
  int unsigned lim_frames;
  int unsigned depth_k;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_victims = 0;
  int n_empty_evicts = 0;

  function automatic void drop_frame(int f);
    if (fr_evict[f] && evict_total > 0) evict_total--;
    fr_tracked[f] = 0;
    fr_evict[f] = 0;
    fr_count[f] = 0;
    fr_head[f] = 0;
  endfunction

  // Apply one operation to the shadow state and return the result it yields
  function automatic out_item_t replace_step(in_item_t it);
    out_item_t r;
    int f;
    int unsigned k, d;
    bit have, best_inf, inf;
    logic [31:0] best_key, key;
    int best;
    r = '0;
    f = it.frame;
    k = (depth_k < 1) ? 1 : (depth_k > KMAX) ? KMAX : depth_k;
    have = 0; best_inf = 0; best_key = '0; best = 0;
    if (stamp_now != 32'hFFFF_FFFF) stamp_now++;
    case (it.op)
      OP_ACCESS: begin
        if (f < lim_frames) begin
          fr_stamps[f][fr_head[f]] = stamp_now;
          fr_head[f] = (fr_head[f] + 1) % KMAX;
          if (fr_count[f] < KMAX) fr_count[f]++;
          fr_tracked[f] = 1;
        end
      end
      OP_SET_EVICT: begin
        if (it.evictable_flag) begin
          if (fr_tracked[f] && !fr_evict[f]) begin
            fr_evict[f] = 1;
            evict_total++;
          end
        end else if (fr_evict[f]) begin
          fr_evict[f] = 0;
          evict_total--;
        end
      end
      OP_REMOVE: drop_frame(f);
      default: begin
        for (int i = 0; i < NFR; i++) begin
          if (fr_tracked[i] && fr_evict[i] && fr_count[i] != 0) begin
            inf = fr_count[i] < k;
            d = inf ? fr_count[i] : k;
            key = fr_stamps[i][(fr_head[i] + KMAX - d) % KMAX];
            if (!have || (inf && !best_inf) || (inf == best_inf && key < best_key)) begin
              have = 1; best_inf = inf; best_key = key; best = i;
            end
          end
        end
        if (have) begin
          drop_frame(best);
          r.found = 1'b1;
          r.victim = best[5:0];
        end
      end
    endcase
    r.evictable_count = evict_total[6:0];
    return r;
  endfunction

  // Driver: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results = {expected_results, replace_step(in_data)};
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_ops.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls follow a mode that is re-drawn at random
  int ready_mode = 0;
  int mode_age = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          errors++;
        end
        if (out_data.victim !== want.victim) begin
          $error("victim: expected %0d, got %0d", want.victim, out_data.victim);
          errors++;
        end
        if (out_data.evictable_count !== want.evictable_count) begin
          $error("evictable_count: expected %0d, got %0d",
                 want.evictable_count, out_data.evictable_count);
          errors++;
        end
        if (want.found) n_victims++;
        else if (out_data.found === 1'b0 && want.evictable_count == 0) n_empty_evicts++;
      end
    end
    mode_age++;
    if (mode_age >= 128) begin
      mode_age = 0;
      ready_mode = $urandom_range(0, 3);
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (mode_age % 16) < 3;
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_lru_k_frame_replacer: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    if (idx == CFG_FRAME_LIMIT) lim_frames = val & 7'h7F;
    else depth_k = val & 4'hF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_op(logic [1:0] op, int f, bit flag);
    in_item_t it;
    it.op = op;
    it.frame = f[5:0];
    it.evictable_flag = flag;
    pending_ops = {pending_ops, it};
  endtask

  // Hold until every transfer is answered, then let the block go idle
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random traffic: accesses, flag changes, removes and evicts, mostly on a small hot set
  task automatic random_ops(int n);
    int hot, f, pick;
    hot = (lim_frames == 0) ? 1 : (lim_frames > 12 ? 12 : lim_frames);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hot - 1);
      if (pick < 45) push_op(OP_ACCESS, f, 1'($urandom_range(0, 1)));
      else if (pick < 68) push_op(OP_SET_EVICT, f, $urandom_range(0, 5) != 0);
      else if (pick < 76) push_op(OP_REMOVE, f, 1'($urandom_range(0, 1)));
      else push_op(OP_EVICT, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned lim_set [8] = '{64, 1, 64, 20, 5, 33, 64, 8};
    int unsigned k_set   [8] = '{2, 1, 8, 0, 15, 3, 1, 5};
    for (int i = 0; i < NFR; i++) begin
      fr_tracked[i] = 0; fr_evict[i] = 0; fr_count[i] = 0; fr_head[i] = 0;
      for (int j = 0; j < KMAX; j++) fr_stamps[i][j] = '0;
    end
    stamp_now = '0;
    evict_total = 0;
    lim_frames = FRAME_LIMIT_RST;
    depth_k = HISTORY_DEPTH_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks at reset settings
    push_op(OP_EVICT, 0, 0);          // nothing to evict
    push_op(OP_SET_EVICT, 5, 1);      // flag on an untracked frame is ignored
    push_op(OP_ACCESS, 0, 0);
    push_op(OP_ACCESS, 63, 1);
    push_op(OP_ACCESS, 63, 0);
    push_op(OP_ACCESS, 0, 1);
    push_op(OP_ACCESS, 7, 0);
    push_op(OP_SET_EVICT, 63, 1);
    push_op(OP_SET_EVICT, 63, 1);     // set twice, count once
    push_op(OP_SET_EVICT, 0, 1);
    push_op(OP_SET_EVICT, 7, 1);
    push_op(OP_EVICT, 0, 0);          // frame 7 has infinite distance
    push_op(OP_EVICT, 0, 0);          // oldest second-last access wins
    push_op(OP_SET_EVICT, 0, 0);      // clear flag
    push_op(OP_SET_EVICT, 0, 0);
    push_op(OP_SET_EVICT, 0, 1);
    push_op(OP_REMOVE, 0, 0);         // remove a frame whose history the evict cleared
    push_op(OP_REMOVE, 42, 1);        // remove an untracked frame
    push_op(OP_EVICT, 63, 1);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_FRAME_LIMIT, lim_set[p]);
      write_reg(CFG_HISTORY_DEPTH, k_set[p]);
      random_ops(250);
      // mid-phase: let every answer arrive before the next batch
      drain();
      random_ops(10);
      drain();
    end

    $display("covered %0d results: %0d victims chosen, %0d results with nothing evictable",
             n_results, n_victims, n_empty_evicts);
    $display("swept frame_limit 1..64 and history depth 0..15 across 8 settings");
    if (errors == 0) begin
      $display("tb_lru_k_frame_replacer: clean");
    end else begin
      $display("tb_lru_k_frame_replacer: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lkr_pkg.sv
hw/rtl/lkr_sync_ram.sv
hw/rtl/lkr_victim_sel.sv
hw/rtl/lru_k_frame_replacer.sv
tb/tb_lru_k_frame_replacer.sv
